FILE: sv/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the UV-sphere vertex evaluator
// Divider step word, polynomial step word, fixed-point constants, rounding.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int unsigned MAX_SEGMENTS  = 255;
    localparam int unsigned DIV_STEPS     = 32;   // quotient bits below the top one
    localparam int unsigned HORNER_STEPS  = 6;
    localparam int unsigned HORNER_LAT    = 3;    // register stages in one polynomial step
    localparam int unsigned SINCOS_LAT    = 2 + HORNER_STEPS * HORNER_LAT + 2;

    // register indexes of the configuration port
    localparam logic REG_RADIUS   = 1'b0;
    localparam logic REG_SEGMENTS = 1'b1;

    localparam logic [32:0] Q30_ONE = 33'd1 << 30;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;   // pi in Q30

    localparam int unsigned SIN_DIVS [0:HORNER_STEPS-1] = '{156, 110, 72, 42, 20, 6};
    localparam int unsigned COS_DIVS [0:HORNER_STEPS-1] = '{182, 132, 90, 56, 30, 12};

    // one long-division step for the theta lane and the phi lane
    typedef struct packed {
        logic [32:0] quo_th;
        logic [32:0] quo_ph;
        logic [7:0]  rem_th;
        logic [7:0]  rem_ph;
    } div_step_t;

    // word moving along the polynomial cells
    typedef struct packed {
        logic [1:0]  quad;
        logic [30:0] x;
        logic [31:0] x2;
        logic [30:0] ts;
        logic [30:0] tc;
    } horner_t;

    // shift right with rounding half away from zero
    function automatic logic signed [63:0] sround(input logic signed [63:0] v,
                                                  input int unsigned sh);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? (64'd0 - $unsigned(v)) : $unsigned(v);
        m = (mag + (64'd1 << (sh - 1))) >> sh;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

endpackage

FILE: sv/uv_sphere_vertex_evaluator_top.sv
// ----------------------------------------------------------------------------
// uv_sphere_vertex_evaluator_top: UV-sphere vertex from a grid point
// Position, normal, texture coordinates and vertex index for (ring, segment).
// ----------------------------------------------------------------------------
//  port group   dir  word
//  s_axis_*     in   grid point: ring_index, segment_index
//  m_axis_*     out  vertex: position, normal, tex u/v, index; tuser flags
//  APB          in   radius (0x0), segment_count (0x4)
//
//  One word per clock in and out while the skid is empty. A word passes the
//  entry register, 32 divider cells, phase register, 22 in each sine/cosine
//  unit, then unit vector, data and output registers to m_axis_tvalid.
//  Reset: synchronous, active low; clears the pipeline, output and skid valid flags.
//  A stalled output word parks one more word in the skid register; the
//  pipeline then holds and s_axis_tready drops until the skid drains.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_evaluator_top import uvs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // ring_index[6:0], segment_index[14:7]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x[16:0], pos_y[33:17], pos_z[50:34], normal_x[66:51],
    // normal_y[82:67], normal_z[98:83], tex_u[115:99], tex_v[132:116],
    // vertex_number[147:133]
    output logic [151:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // point_valid[0], cell_valid[1]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned LAT   = 1 + DIV_STEPS + 1 + SINCOS_LAT + 2;

    typedef struct packed {
        logic [6:0]  ring;
        logic [7:0]  seg;
        logic        pv;
        logic        cv;
        logic [14:0] vnum;
    } side_a_t;

    typedef struct packed {
        logic        pv;
        logic        cv;
        logic [14:0] vnum;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } side_b_t;

    logic [15:0] radius_reg;
    logic [7:0]  seg_cnt_reg;

    logic        ce;
    logic        in_acc;
    logic [6:0]  in_ring;
    logic [7:0]  in_seg;
    logic [7:0]  s_eff;
    logic [6:0]  rings;
    logic [7:0]  d_phi;
    logic [6:0]  hs;
    logic        ge_th0, ge_ph0;
    div_step_t   div_init;
    side_a_t     side_in;

    logic        vld_reg [0:LAT-1];
    side_a_t     side_a_reg [0:DIV_STEPS];
    side_b_t     side_b_reg [0:SINCOS_LAT+1];
    div_step_t   div_chain [0:DIV_STEPS];
    div_step_t   div0_reg;

    div_step_t   dq;
    side_a_t     sa;
    logic [16:0] qu, qv;
    logic [24:0] ru, rv;
    side_b_t     side_b_next;
    logic [31:0] ph_th_reg, ph_ph_reg;
    logic [31:0] ph_th_next, ph_ph_next;

    logic signed [31:0] sin_th, cos_th, sin_ph, cos_ph;
    logic signed [63:0] prod_px, prod_pz;
    logic signed [31:0] px1_reg, pz1_reg, cp1_reg;
    logic signed [16:0] rad_s;
    logic signed [63:0] prod_x, prod_y, prod_z;
    logic [151:0] fin_data_next;
    logic [151:0] fin_data_reg;
    logic [1:0]   fin_user_reg;
    side_b_t      sb;

    logic         m_valid_reg;
    logic [151:0] m_data_reg;
    logic [1:0]   m_user_reg;
    logic         skid_valid_reg;
    logic [151:0] skid_data_reg;
    logic [1:0]   skid_user_reg;
    logic         out_free;

    // ---------------- configuration ----------------
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= 16'd256;
            seg_cnt_reg <= 8'd32;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_RADIUS:   radius_reg  <= pwdata[15:0];
                REG_SEGMENTS: seg_cnt_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_RADIUS:   prdata = {16'd0, radius_reg};
            REG_SEGMENTS: prdata = {24'd0, seg_cnt_reg};
            default:      prdata = '0;
        endcase
    end

    // the user must keep config stable while words are in flight; the block does not enforce this and uses it directly
    always_comb begin
        if (seg_cnt_reg < 8'd2) begin
            s_eff = 8'd2;
        end else if (32'(seg_cnt_reg) > MAX_SEGMENTS) begin
            s_eff = 8'(MAX_SEGMENTS);
        end else begin
            s_eff = seg_cnt_reg;
        end
    end
    assign rings = s_eff[7:1];
    assign d_phi = {rings, 1'b0};
    assign hs    = s_eff[7:1];

    // ---------------- entry ----------------
    assign ce            = !skid_valid_reg;
    assign s_axis_tready = ce;
    assign in_acc        = s_axis_tvalid && ce;
    assign in_ring       = s_axis_tdata[6:0];
    assign in_seg        = s_axis_tdata[14:7];

    always_comb begin
        side_in.ring = in_ring;
        side_in.seg  = in_seg;
        side_in.pv   = (in_ring <= rings) && (in_seg <= s_eff);
        side_in.cv   = (in_ring < rings) && (in_seg < s_eff);
        side_in.vnum = 15'(17'(in_ring) * 17'({1'b0, s_eff} + 9'd1) + 17'(in_seg));
        // top quotient bit of x*2^32/d, with x no larger than d
        ge_th0 = in_seg >= s_eff;
        ge_ph0 = {1'b0, in_ring} >= d_phi;
        div_init.quo_th = {32'd0, ge_th0};
        div_init.quo_ph = {32'd0, ge_ph0};
        div_init.rem_th = ge_th0 ? (in_seg - s_eff) : in_seg;
        div_init.rem_ph = ge_ph0 ? ({1'b0, in_ring} - d_phi) : {1'b0, in_ring};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (ce) begin
            vld_reg[0] <= in_acc;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            div0_reg      <= div_init;
            side_a_reg[0] <= side_in;
            for (int i = 1; i <= DIV_STEPS; i++) begin
                side_a_reg[i] <= side_a_reg[i-1];
            end
        end
    end

    // ---------------- divider row ----------------
    assign div_chain[0] = div0_reg;

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        uvs_div_cell u_div (
            .aclk  (aclk),
            .ce    (ce),
            .dvs_th(s_eff),
            .dvs_ph(d_phi),
            .din   (div_chain[k]),
            .dout  (div_chain[k+1])
        );
    end

    // ---------------- phases and texture coordinates ----------------
    always_comb begin
        dq = div_chain[DIV_STEPS];
        sa = side_a_reg[DIV_STEPS];
        ph_th_next = dq.quo_th[31:0]
                   + 32'((9'(dq.rem_th) + 9'(hs)) >= 9'(s_eff));
        ph_ph_next = dq.quo_ph[31:0]
                   + 32'((9'(dq.rem_ph) + 9'(rings)) >= 9'(d_phi));
        // floor(seg*2^16/S) and floor(ring*2^16/R) are upper quotient bits
        qu = dq.quo_th[32:16];
        qv = dq.quo_ph[31:15];
        ru = {1'b0, sa.seg, 16'd0} - 25'(qu) * 25'(s_eff);
        rv = {2'b0, sa.ring, 16'd0} - 25'(qv) * 25'(rings);
        side_b_next.pv    = sa.pv;
        side_b_next.cv    = sa.cv;
        side_b_next.vnum  = sa.vnum;
        side_b_next.tex_u = qu + 17'((ru + 25'(hs)) >= 25'(s_eff));
        side_b_next.tex_v = qv + 17'((rv + 25'(rings[6:1])) >= 25'(rings));
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ph_th_reg     <= ph_th_next;
            ph_ph_reg     <= ph_ph_next;
            side_b_reg[0] <= side_b_next;
            for (int i = 1; i <= SINCOS_LAT + 1; i++) begin
                side_b_reg[i] <= side_b_reg[i-1];
            end
        end
    end

    // ---------------- sine and cosine ----------------
    uvs_sincos u_sc_th (
        .aclk   (aclk),
        .ce     (ce),
        .phase  (ph_th_reg),
        .sin_q30(sin_th),
        .cos_q30(cos_th)
    );

    uvs_sincos u_sc_ph (
        .aclk   (aclk),
        .ce     (ce),
        .phase  (ph_ph_reg),
        .sin_q30(sin_ph),
        .cos_q30(cos_ph)
    );

    // ---------------- unit vector, then scale ----------------
    assign prod_px = sin_ph * cos_th;
    assign prod_pz = sin_ph * sin_th;
    assign rad_s   = $signed({1'b0, radius_reg});
    assign prod_x  = px1_reg * rad_s;
    assign prod_y  = cp1_reg * rad_s;
    assign prod_z  = pz1_reg * rad_s;
    assign sb      = side_b_reg[SINCOS_LAT + 1];

    always_comb begin
        fin_data_next = {4'd0, sb.vnum, sb.tex_v, sb.tex_u,
                         16'(sround(64'(pz1_reg), 16)),
                         16'(sround(64'(cp1_reg), 16)),
                         16'(sround(64'(px1_reg), 16)),
                         17'(sround(prod_z, 30)),
                         17'(sround(prod_y, 30)),
                         17'(sround(prod_x, 30))};
        if (!sb.pv) begin
            fin_data_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            px1_reg      <= 32'(sround(prod_px, 30));
            pz1_reg      <= 32'(sround(prod_pz, 30));
            cp1_reg      <= cos_ph;
            fin_data_reg <= fin_data_next;
            fin_user_reg <= {sb.cv && sb.pv, sb.pv};
        end
    end

    // ---------------- output register and skid ----------------
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= vld_reg[LAT-1];
            end
        end else if (ce && vld_reg[LAT-1]) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end else begin
                m_data_reg <= fin_data_reg;
                m_user_reg <= fin_user_reg;
            end
        end else if (ce) begin
            skid_data_reg <= fin_data_reg;
            skid_user_reg <= fin_user_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef ASSERT_OFF
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_axis_tvalid)
        else $error("skid holds a word while output is empty");

    a_skid_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid loaded without an output stall");

    a_cell_in_grid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (!m_axis_tuser[1] || m_axis_tuser[0]))
        else $error("cell flag set on a point outside the grid");

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("point outside the grid gives nonzero data");
`endif

endmodule

FILE: sv/uvs_div_cell.sv
// ----------------------------------------------------------------------------
// uvs_div_cell: one restoring division step
// Produces one quotient bit for the theta lane and one for the phi lane.
// ----------------------------------------------------------------------------
module uvs_div_cell import uvs_pkg::*; (
    input  logic      aclk,
    input  logic      ce,
    input  logic [7:0] dvs_th,
    input  logic [7:0] dvs_ph,
    input  div_step_t din,
    output div_step_t dout
);

    div_step_t step_reg;
    div_step_t step_next;
    logic [8:0] r2_th;
    logic [8:0] r2_ph;
    logic       ge_th;
    logic       ge_ph;

    always_comb begin
        r2_th = {din.rem_th, 1'b0};
        r2_ph = {din.rem_ph, 1'b0};
        ge_th = r2_th >= {1'b0, dvs_th};
        ge_ph = r2_ph >= {1'b0, dvs_ph};
        step_next.rem_th = ge_th ? 8'(r2_th - {1'b0, dvs_th}) : r2_th[7:0];
        step_next.rem_ph = ge_ph ? 8'(r2_ph - {1'b0, dvs_ph}) : r2_ph[7:0];
        step_next.quo_th = {din.quo_th[31:0], ge_th};
        step_next.quo_ph = {din.quo_ph[31:0], ge_ph};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            step_reg <= step_next;
        end
    end

    assign dout = step_reg;

endmodule

FILE: sv/uvs_horner_cell.sv
// ----------------------------------------------------------------------------
// uvs_horner_cell: one Horner step of the sine and cosine polynomials
// t = 1 - round(round(x2*t) / d) in Q30, three register stages.
// ----------------------------------------------------------------------------
module uvs_horner_cell import uvs_pkg::*; #(
    parameter int unsigned SIN_DIV = 6,
    parameter int unsigned COS_DIV = 12
) (
    input  logic    aclk,
    input  logic    ce,
    input  horner_t din,
    output horner_t dout
);

    localparam logic [31:0] RECIP_S = 32'((64'd1 << 32) / SIN_DIV);
    localparam logic [31:0] RECIP_C = 32'((64'd1 << 32) / COS_DIV);
    localparam logic [62:0] RND29   = 63'd1 << 29;

    horner_t     b1_reg;
    horner_t     b2_reg;
    horner_t     out_reg;
    horner_t     out_next;
    logic [32:0] as1_reg, ac1_reg;
    logic [32:0] as2_reg, ac2_reg;
    logic [32:0] qs2_reg, qc2_reg;
    logic [62:0] ms, mc;
    logic [32:0] as1_next, ac1_next;
    logic [64:0] ps, pc;
    logic [32:0] rs, rc;
    logic [32:0] qs, qc;

    // stage 1: product rounded back to Q30, plus half the divisor
    assign ms = 63'(din.x2) * 63'(din.ts);
    assign mc = 63'(din.x2) * 63'(din.tc);
    assign as1_next = 33'((ms + RND29) >> 30) + 33'(SIN_DIV / 2);
    assign ac1_next = 33'((mc + RND29) >> 30) + 33'(COS_DIV / 2);

    // stage 2: reciprocal estimate, at most two short of the quotient
    assign ps = 65'(as1_reg) * 65'(RECIP_S);
    assign pc = 65'(ac1_reg) * 65'(RECIP_C);

    // stage 3: correction
    assign rs = as2_reg - 33'(qs2_reg * 33'(SIN_DIV));
    assign rc = ac2_reg - 33'(qc2_reg * 33'(COS_DIV));
    assign qs = qs2_reg + 33'(rs >= 33'(SIN_DIV)) + 33'(rs >= 33'(2 * SIN_DIV));
    assign qc = qc2_reg + 33'(rc >= 33'(COS_DIV)) + 33'(rc >= 33'(2 * COS_DIV));

    always_comb begin
        out_next    = b2_reg;
        out_next.ts = 31'(Q30_ONE - qs);
        out_next.tc = 31'(Q30_ONE - qc);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b1_reg     <= din;
            as1_reg    <= as1_next;
            ac1_reg    <= ac1_next;
            b2_reg     <= b1_reg;
            as2_reg    <= as1_reg;
            ac2_reg    <= ac1_reg;
            qs2_reg    <= ps[64:32];
            qc2_reg    <= pc[64:32];
            out_reg    <= out_next;
        end
    end

    assign dout = out_reg;

endmodule

FILE: sv/uvs_sincos.sv
// ----------------------------------------------------------------------------
// uvs_sincos: sine and cosine of a Q32 fraction of a turn
// Angle scaling, a row of Horner cells, quadrant folding; signed Q30 out.
// ----------------------------------------------------------------------------
module uvs_sincos import uvs_pkg::*; (
    input  logic               aclk,
    input  logic               ce,
    input  logic [31:0]        phase,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);

    localparam logic [62:0] RND29 = 63'd1 << 29;
    localparam logic [62:0] RND30 = 63'd1 << 30;

    logic [1:0]  quad1_reg;
    logic [30:0] x1_reg;
    logic [1:0]  quad2_reg;
    logic [30:0] x2x_reg;
    logic [31:0] x2_reg;
    horner_t     hn [0:HORNER_STEPS];
    logic [1:0]  quad3_reg;
    logic [30:0] s3_reg;
    logic [30:0] c3_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic [62:0] mx;
    logic [62:0] mxx;
    logic [62:0] msn;
    logic [62:0] mcs;
    logic [32:0] p;
    logic [32:0] y;
    logic signed [31:0] s_s;
    logic signed [31:0] c_s;

    assign mx  = 63'(phase[29:0]) * 63'(PI_Q30);
    assign mxx = 63'(x1_reg) * 63'(x1_reg);

    assign hn[0] = '{quad: quad2_reg, x: x2x_reg, x2: x2_reg,
                     ts: Q30_ONE[30:0], tc: Q30_ONE[30:0]};

    for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_cell
        uvs_horner_cell #(
            .SIN_DIV(SIN_DIVS[i]),
            .COS_DIV(COS_DIVS[i])
        ) u_cell (
            .aclk(aclk),
            .ce  (ce),
            .din (hn[i]),
            .dout(hn[i+1])
        );
    end

    assign msn = 63'(hn[HORNER_STEPS].x) * 63'(hn[HORNER_STEPS].ts);
    assign mcs = 63'(hn[HORNER_STEPS].x2) * 63'(hn[HORNER_STEPS].tc);
    assign p   = 33'((mcs + RND29) >> 30);
    assign y   = (p + 33'd1) >> 1;
    assign s_s = $signed({1'b0, s3_reg});
    assign c_s = $signed({1'b0, c3_reg});

    always_ff @(posedge aclk) begin
        if (ce) begin
            quad1_reg <= phase[31:30];
            x1_reg    <= 31'((mx + RND30) >> 31);
            quad2_reg <= quad1_reg;
            x2x_reg   <= x1_reg;
            x2_reg    <= 32'((mxx + RND29) >> 30);
            quad3_reg <= hn[HORNER_STEPS].quad;
            s3_reg    <= 31'((msn + RND29) >> 30);
            c3_reg    <= (y > Q30_ONE) ? 31'd0 : 31'(Q30_ONE - y);
            case (quad3_reg)
                2'd0: begin
                    sin_reg <= s_s;
                    cos_reg <= c_s;
                end
                2'd1: begin
                    sin_reg <= c_s;
                    cos_reg <= -s_s;
                end
                2'd2: begin
                    sin_reg <= -s_s;
                    cos_reg <= -c_s;
                end
                default: begin
                    sin_reg <= -c_s;
                    cos_reg <= s_s;
                end
            endcase
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: UV-sphere vertex evaluator check
// Streams grid points through the block under several radius and segment
// settings and random stalls on both sides. Each output word is compared
// field by field with a local fixed-point model of the vertex math.
// ----------------------------------------------------------------------------
module testbench;
    import uvs_pkg::*;

    localparam logic [2:0] ADDR_RADIUS   = {REG_RADIUS, 2'b00};
    localparam logic [2:0] ADDR_SEGMENTS = {REG_SEGMENTS, 2'b00};
    localparam int         DRAIN_CYCLES = 70;
    localparam int         NUM_FIELDS   = 9;

    typedef struct packed {
        logic [151:0] data;
        logic [1:0]   flags;
    } vertex_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    vertex_t      pending_vertices[$];
    int           errors = 0;
    int           send_idle = 0;
    int           recv_idle = 0;
    int unsigned  cfg_radius = 256;
    int unsigned  cfg_segments = 32;

    // field table of the output word, lowest bit first
    string        fld_name [NUM_FIELDS] = '{"pos_x", "pos_y", "pos_z", "normal_x",
        "normal_y", "normal_z", "tex_u", "tex_v", "vertex_number"};
    int           fld_lsb  [NUM_FIELDS] = '{0, 17, 34, 51, 67, 83, 99, 116, 133};
    int           fld_width[NUM_FIELDS] = '{17, 17, 17, 16, 16, 16, 17, 17, 15};

    uv_sphere_vertex_evaluator_top dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------- fixed-point model ----------------
    function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic longint unsigned div_rnd(longint unsigned a, longint unsigned d);
        return (a + d / 2) / d;
    endfunction

    function automatic longint shr_rnd(longint v, int sh);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    task automatic turn_sincos(input longint unsigned phase, output longint sn,
                               output longint cs);
        longint unsigned one, quad, r, x, x2, t, s, c, y;
        one = 64'd1 << 30;
        quad = (phase >> 30) & 3;
        r = phase & (one - 1);
        x = (r * PI_Q30 + one) >> 31;
        x2 = mul_q30(x, x);
        t = one;
        for (int i = 0; i < 6; i++) t = one - div_rnd(mul_q30(x2, t), SIN_DIVS[i]);
        s = mul_q30(x, t);
        t = one;
        for (int i = 0; i < 6; i++) t = one - div_rnd(mul_q30(x2, t), COS_DIVS[i]);
        y = div_rnd(mul_q30(x2, t), 2);
        c = (y > one) ? 0 : one - y;
        case (quad)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    task automatic vertex_predict(input int unsigned ring, input int unsigned seg,
                                  output vertex_t v);
        longint unsigned nseg, nring, ph_phi, ph_th;
        longint sp, cp, st, ct, px, pz, rad;
        logic [16:0] ox, oy, oz, u, tv;
        logic [15:0] nx, ny, nz;
        logic [14:0] vn;
        nseg = 64'((cfg_segments < 2) ? 2 : (cfg_segments > MAX_SEGMENTS) ? MAX_SEGMENTS
                                                                        : cfg_segments);
        nring = nseg / 2;
        v = '0;
        if (ring > nring || seg > nseg) return;
        ph_phi = ((longint'(ring) << 32) + nring) / (2 * nring);
        ph_th = (((longint'(seg) << 32) + nseg / 2) / nseg) & 64'hFFFF_FFFF;
        turn_sincos(ph_phi, sp, cp);
        turn_sincos(ph_th, st, ct);
        px = shr_rnd(sp * ct, 30);
        pz = shr_rnd(sp * st, 30);
        rad = longint'(cfg_radius);
        ox = 17'(shr_rnd(px * rad, 30));
        oy = 17'(shr_rnd(cp * rad, 30));
        oz = 17'(shr_rnd(pz * rad, 30));
        nx = 16'(shr_rnd(px, 16));
        ny = 16'(shr_rnd(cp, 16));
        nz = 16'(shr_rnd(pz, 16));
        u  = 17'(div_rnd(longint'(seg) << 16, nseg));
        tv = 17'(div_rnd(longint'(ring) << 16, nring));
        vn = 15'(ring * (nseg + 1) + seg);
        v.data = {4'd0, vn, tv, u, nz, ny, nx, oz, oy, ox};
        v.flags = {(ring < nring && seg < nseg) ? 1'b1 : 1'b0, 1'b1};
    endtask

    // ---------------- output side ----------------
    always @(posedge aclk) begin
        vertex_t want;
        logic [16:0] e, a;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_vertices.size() == 0) begin
                $error("vertex word with no expectation pending");
                errors++;
            end else begin
                want = pending_vertices.pop_front();
                for (int f = 0; f < NUM_FIELDS; f++) begin
                    e = 17'((want.data >> fld_lsb[f]) & ((1 << fld_width[f]) - 1));
                    a = 17'((m_axis_tdata >> fld_lsb[f]) & ((1 << fld_width[f]) - 1));
                    if (e !== a) begin
                        $error("%s: expected %h, got %h", fld_name[f], e, a);
                        errors++;
                    end
                end
                if (want.data[151:148] !== m_axis_tdata[151:148]) begin
                    $error("tdata pad: expected %h, got %h", want.data[151:148],
                           m_axis_tdata[151:148]);
                    errors++;
                end
                if (want.flags[0] !== m_axis_tuser[0]) begin
                    $error("point_valid: expected %b, got %b", want.flags[0],
                           m_axis_tuser[0]);
                    errors++;
                end
                if (want.flags[1] !== m_axis_tuser[1]) begin
                    $error("cell_valid: expected %b, got %b", want.flags[1],
                           m_axis_tuser[1]);
                    errors++;
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end

    // ---------------- input side ----------------
    task automatic send_point(input int unsigned ring, input int unsigned seg);
        vertex_t v;
        // the block only sees the low field bits
        vertex_predict(ring & 32'h7F, seg & 32'hFF, v);
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, seg[7:0], ring[6:0]};
        do @(posedge aclk); while (!s_axis_tready);
        pending_vertices = {pending_vertices, v};
    endtask

    task automatic drain_vertices();
        s_axis_tvalid <= 1'b0;
        while (pending_vertices.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_RADIUS) cfg_radius = 32'(value[15:0]);
        else if (addr == ADDR_SEGMENTS) cfg_segments = 32'(value[7:0]);
        @(posedge aclk);
    endtask

    task automatic set_sphere(input int unsigned rad, input int unsigned segs);
        drain_vertices();
        apb_write(ADDR_RADIUS, rad);
        apb_write(ADDR_SEGMENTS, segs);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed();
        int unsigned nseg, nring;
        nseg = (cfg_segments < 2) ? 2 : cfg_segments;
        nring = nseg / 2;
        send_point(0, 0);
        send_point(nring, 0);
        send_point(nring, nseg);
        send_point(0, nseg);
        send_point(nring - 1, nseg - 1);
        send_point(nring / 2, nseg / 4);
        send_point(nring + 1, 0);
        send_point(0, nseg + 1);
        send_point(127, 255);
        send_point(1, 1);
    endtask

    task automatic test_random(input int count);
        int unsigned nseg, nring;
        nseg = (cfg_segments < 2) ? 2 : cfg_segments;
        nring = nseg / 2;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) == 0)
                send_point($urandom_range(127), $urandom_range(255));
            else
                send_point($urandom_range(nring), $urandom_range(nseg));
            // at the halfway point, sometimes let the pipe empty with the sender holding off
            if (i == count / 2 && $urandom_range(3) == 0) drain_vertices();
        end
    endtask

    task automatic test_phase(input int count);
        int unsigned rad, segs;
        test_directed();
        test_random(count);
        rad = $urandom_range(65535);
        segs = $urandom_range(2, 255);
        set_sphere(rad, segs);
        test_random(count);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle = 8;
        recv_idle = 68;
        test_directed();
        test_random(100);
        drain_vertices();           // sender pause until all words are back
        set_sphere(0, 255);
        test_phase(150);
        set_sphere(65535, 2);
        test_phase(100);
        send_idle = 68;
        recv_idle = 8;
        set_sphere(65535, 0);
        test_phase(100);
        set_sphere(256, 1);
        test_phase(100);
        set_sphere(1000, 254);
        test_phase(150);
        send_idle = 0;
        recv_idle = 0;
        set_sphere(65535, 255);
        test_phase(100);
        set_sphere(12345, 3);
        test_phase(150);
        drain_vertices();
        if (errors == 0) begin
            $display("uv_sphere_vertex_evaluator_top test passed");
        end else begin
            $display("uv_sphere_vertex_evaluator_top test failed");
        end
        $finish;
    end

    initial begin
        #(8 * 400000);
        $display("uv_sphere_vertex_evaluator_top test failed");
        $finish;
    end

endmodule

FILE: uv_sphere_vertex_evaluator_top.f
sv/uvs_pkg.sv
sv/uvs_div_cell.sv
sv/uvs_horner_cell.sv
sv/uvs_sincos.sv
sv/uv_sphere_vertex_evaluator_top.sv
sim/testbench.sv
